// ----- rtl/hdu_pkg.sv -----
// ----------------------------------------------------------------------------
// hdu_pkg
// Widths, fixed-point constants and the CORDIC arctangent table shared by the
// haversine distance unit and its parts.
// ----------------------------------------------------------------------------
package hdu_pkg;

    // field widths
    localparam int LAT_W   = 24;
    localparam int LON_W   = 25;
    localparam int RAD_W   = 16;
    localparam int CFG_W   = 25;
    localparam int DIST_W  = 28;

    // angle to phase
    localparam int DIFF_W  = 26;
    localparam int PHASE_W = 32;
    localparam logic [DIFF_W-1:0] DEG_MOD_HALF = 26'd47185920;  // 720 degrees, Q16
    localparam logic [DIFF_W-1:0] DEG_MOD_FULL = 26'd23592960;  // 360 degrees, Q16
    localparam int RECIP_W  = 27;
    localparam logic [RECIP_W-1:0] RECIP_45 = 27'd95443718;     // ceil(2^32 / 45)
    localparam int RECIP_SH = 32;
    localparam int DIV_45   = 45;
    localparam int QUO_W    = 21;
    localparam int REM_W    = 6;
    localparam int HALF_FRAC = 12;
    localparam int FULL_FRAC = 13;

    // cordic
    localparam int CORDIC_ITERS = 30;
    localparam int XY_W   = 34;
    localparam int TRIG_W = 32;
    localparam int CORDIC_K = 652032874;
    localparam int Q30_FRAC = 30;

    // square root
    localparam int ROOT_W = 31;
    localparam int SQ_W   = 2 * ROOT_W;
    localparam logic [ROOT_W-1:0] Q30_ONE = 31'h4000_0000;

    // scaling
    localparam int PI_W = 18;
    localparam logic [PI_W-1:0] PI_Q16 = 18'd205887;
    localparam logic [DIST_W-1:0] DIST_MAX = 28'hFFF_FFFF;
    localparam logic [DIST_W-1:0] DIST_PEAK = 28'd210825071;  // largest reachable distance

    function automatic logic [29:0] atan_phase(input int idx);
        case (idx)
            0:  atan_phase = 30'd536870912;
            1:  atan_phase = 30'd316933406;
            2:  atan_phase = 30'd167458907;
            3:  atan_phase = 30'd85004756;
            4:  atan_phase = 30'd42667331;
            5:  atan_phase = 30'd21354465;
            6:  atan_phase = 30'd10679838;
            7:  atan_phase = 30'd5340245;
            8:  atan_phase = 30'd2670163;
            9:  atan_phase = 30'd1335087;
            10: atan_phase = 30'd667544;
            11: atan_phase = 30'd333772;
            12: atan_phase = 30'd166886;
            13: atan_phase = 30'd83443;
            14: atan_phase = 30'd41722;
            15: atan_phase = 30'd20861;
            16: atan_phase = 30'd10430;
            17: atan_phase = 30'd5215;
            18: atan_phase = 30'd2608;
            19: atan_phase = 30'd1304;
            20: atan_phase = 30'd652;
            21: atan_phase = 30'd326;
            22: atan_phase = 30'd163;
            23: atan_phase = 30'd81;
            24: atan_phase = 30'd41;
            25: atan_phase = 30'd20;
            26: atan_phase = 30'd10;
            27: atan_phase = 30'd5;
            28: atan_phase = 30'd3;
            29: atan_phase = 30'd1;
            default: atan_phase = 30'd0;
        endcase
    endfunction

endpackage

// ----- rtl/hdu_sincos.sv -----
// ----------------------------------------------------------------------------
// hdu_sincos
// Pipelined CORDIC rotation: one iteration per stage, then a quadrant stage.
// Phase is 32 bits per full turn, results are Q30.
// ----------------------------------------------------------------------------
module hdu_sincos
    import hdu_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [PHASE_W-1:0]        i_phase,
    output logic signed [TRIG_W-1:0]  o_sin,
    output logic signed [TRIG_W-1:0]  o_cos
);

    logic signed [XY_W-1:0] r_x [CORDIC_ITERS];
    logic signed [XY_W-1:0] r_y [CORDIC_ITERS];
    logic signed [XY_W-1:0] r_z [CORDIC_ITERS];
    logic [1:0]             r_q [CORDIC_ITERS];

    logic signed [XY_W-1:0] x_src [CORDIC_ITERS];
    logic signed [XY_W-1:0] y_src [CORDIC_ITERS];
    logic signed [XY_W-1:0] z_src [CORDIC_ITERS];
    logic [1:0]             q_src [CORDIC_ITERS];

    logic signed [XY_W-1:0] n_x [CORDIC_ITERS];
    logic signed [XY_W-1:0] n_y [CORDIC_ITERS];
    logic signed [XY_W-1:0] n_z [CORDIC_ITERS];

    logic signed [TRIG_W-1:0] r_sin, n_sin;
    logic signed [TRIG_W-1:0] r_cos, n_cos;

    always_comb begin
        x_src[0] = XY_W'(CORDIC_K);
        y_src[0] = '0;
        z_src[0] = XY_W'(i_phase[PHASE_W-3:0]);
        q_src[0] = i_phase[PHASE_W-1:PHASE_W-2];
        for (int i = 1; i < CORDIC_ITERS; i++) begin
            x_src[i] = r_x[i-1];
            y_src[i] = r_y[i-1];
            z_src[i] = r_z[i-1];
            q_src[i] = r_q[i-1];
        end
        for (int i = 0; i < CORDIC_ITERS; i++) begin
            if (!z_src[i][XY_W-1]) begin
                n_x[i] = x_src[i] - (y_src[i] >>> i);
                n_y[i] = y_src[i] + (x_src[i] >>> i);
                n_z[i] = z_src[i] - XY_W'(atan_phase(i));
            end else begin
                n_x[i] = x_src[i] + (y_src[i] >>> i);
                n_y[i] = y_src[i] - (x_src[i] >>> i);
                n_z[i] = z_src[i] + XY_W'(atan_phase(i));
            end
        end
    end

    // quadrant 0 holds cos in x and sin in y
    always_comb begin
        case (r_q[CORDIC_ITERS-1])
            2'd0: begin
                n_sin = TRIG_W'(r_y[CORDIC_ITERS-1]);
                n_cos = TRIG_W'(r_x[CORDIC_ITERS-1]);
            end
            2'd1: begin
                n_sin = TRIG_W'(r_x[CORDIC_ITERS-1]);
                n_cos = TRIG_W'(-r_y[CORDIC_ITERS-1]);
            end
            2'd2: begin
                n_sin = TRIG_W'(-r_y[CORDIC_ITERS-1]);
                n_cos = TRIG_W'(-r_x[CORDIC_ITERS-1]);
            end
            default: begin
                n_sin = TRIG_W'(-r_x[CORDIC_ITERS-1]);
                n_cos = TRIG_W'(r_y[CORDIC_ITERS-1]);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < CORDIC_ITERS; i++) begin
                r_x[i] <= n_x[i];
                r_y[i] <= n_y[i];
                r_z[i] <= n_z[i];
                r_q[i] <= q_src[i];
            end
            r_sin <= n_sin;
            r_cos <= n_cos;
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

// ----- rtl/hdu_isqrt.sv -----
// ----------------------------------------------------------------------------
// hdu_isqrt
// Pipelined digit-by-digit floor square root of a Q30 fraction scaled by 2^30.
// One result bit per stage.
// ----------------------------------------------------------------------------
module hdu_isqrt
    import hdu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [ROOT_W-1:0] i_a,
    output logic [ROOT_W-1:0] o_root
);

    logic [SQ_W-1:0] r_rem  [ROOT_W];
    logic [SQ_W-1:0] r_root [ROOT_W];

    logic [SQ_W-1:0] rem_src  [ROOT_W];
    logic [SQ_W-1:0] root_src [ROOT_W];
    logic [SQ_W-1:0] trial    [ROOT_W];
    logic [SQ_W-1:0] bit_val  [ROOT_W];
    logic [SQ_W-1:0] n_rem    [ROOT_W];
    logic [SQ_W-1:0] n_root   [ROOT_W];

    always_comb begin
        rem_src[0]  = SQ_W'({i_a, Q30_FRAC'(0)});
        root_src[0] = '0;
        for (int i = 1; i < ROOT_W; i++) begin
            rem_src[i]  = r_rem[i-1];
            root_src[i] = r_root[i-1];
        end
        for (int i = 0; i < ROOT_W; i++) begin
            bit_val[i] = SQ_W'(1) << (2 * (ROOT_W - 1 - i));
            trial[i]   = root_src[i] + bit_val[i];
            if (rem_src[i] >= trial[i]) begin
                n_rem[i]  = rem_src[i] - trial[i];
                n_root[i] = (root_src[i] >> 1) + bit_val[i];
            end else begin
                n_rem[i]  = rem_src[i];
                n_root[i] = root_src[i] >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < ROOT_W; i++) begin
                r_rem[i]  <= n_rem[i];
                r_root[i] <= n_root[i];
            end
        end
    end

    assign o_root = r_root[ROOT_W-1][ROOT_W-1:0];

endmodule

// ----- rtl/haversine_distance_unit.sv -----
// ----------------------------------------------------------------------------
// haversine_distance_unit
// Great-circle distance from a configured reference point, in 1/1024 km.
//
//   channel   direction  handshake                  payload
//   point     in         i_valid / o_stall          i_point_lat, i_point_lon
//   distance  out        o_valid / i_stall          o_distance
//   config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One point per cycle while no result is held; 105 register stages, from the
// phase lanes to the output register, lie between a request and its result.
// The stage count is set by the two 30-step cordic chains and the 31-step root,
// one step per stage, plus phase, quadrant, product and scaling stages.
// Reset empties the pipeline and loads the default reference and radius.
// A held result freezes the whole pipeline and stalls the input side.
// ----------------------------------------------------------------------------
module haversine_distance_unit
    import hdu_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic signed [LAT_W-1:0]  i_point_lat,
    input  logic signed [LON_W-1:0]  i_point_lon,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [DIST_W-1:0]        o_distance,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [1:0]               i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data
);

    typedef enum logic [1:0] {
        CFG_REF_LAT = 2'd0,
        CFG_REF_LON = 2'd1,
        CFG_RADIUS  = 2'd2
    } t_cfg_index;

    localparam int LANES  = 4;
    localparam int F3_W   = DIFF_W + RECIP_W;
    localparam int FP_W   = REM_W + RECIP_W;
    localparam int PW     = 2 * TRIG_W;
    localparam int PQ_W   = 33;
    localparam int PW2    = 2 * PQ_W;
    localparam int AS_W   = PQ_W + 1;
    localparam int M1_W   = ROOT_W + RAD_W;
    localparam int SPLIT  = 24;
    localparam int LO_W   = SPLIT + PI_W;
    localparam int HI_W   = M1_W - SPLIT + PI_W;
    localparam int SUM_W  = 65;
    localparam int ROUND_SH = 36;
    localparam int RES_W  = SUM_W - ROUND_SH;
    localparam int LAT    = 6 + (CORDIC_ITERS + 1) + 3 + ROOT_W + CORDIC_ITERS + 4;

    // configuration
    logic signed [LAT_W-1:0] r_ref_lat;
    logic signed [LON_W-1:0] r_ref_lon;
    logic [RAD_W-1:0]        r_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_lat <= '0;
            r_ref_lon <= '0;
            r_radius  <= RAD_W'(6371);
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_REF_LAT: r_ref_lat <= i_cfg_data[LAT_W-1:0];
                CFG_REF_LON: r_ref_lon <= i_cfg_data[LON_W-1:0];
                CFG_RADIUS:  r_radius  <= i_cfg_data[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // pipeline control
    logic             pipe_en;
    logic [LAT-1:0]   r_vld;

    assign pipe_en = !(r_vld[LAT-1] && i_stall);
    assign o_stall = r_vld[LAT-1] && i_stall;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (pipe_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // angle to phase; lanes: dlat/2, dlon/2, reference lat, point lat
    logic [DIFF_W-1:0]  r_f1 [LANES], n_f1 [LANES];
    logic [DIFF_W-1:0]  r_f2 [LANES], n_f2 [LANES];
    logic [F3_W-1:0]    r_f3 [LANES], n_f3 [LANES];
    logic [DIFF_W-1:0]  r_f3_u [LANES];
    logic [QUO_W-1:0]   r_f4_q [LANES], n_f4_q [LANES];
    logic [REM_W-1:0]   r_f4_r [LANES], n_f4_r [LANES];
    logic [QUO_W-1:0]   r_f5_q [LANES];
    logic [FP_W-1:0]    r_f5_fp [LANES], n_f5_fp [LANES];
    logic [PHASE_W-1:0] r_phase [LANES], n_phase [LANES];

    always_comb begin
        n_f1[0] = DIFF_W'(i_point_lat) - DIFF_W'(r_ref_lat);
        n_f1[1] = DIFF_W'(i_point_lon) - DIFF_W'(r_ref_lon);
        n_f1[2] = DIFF_W'(r_ref_lat);
        n_f1[3] = DIFF_W'(i_point_lat);
        for (int l = 0; l < LANES; l++) begin
            if (r_f1[l][DIFF_W-1]) begin
                n_f2[l] = r_f1[l] + ((l < 2) ? DEG_MOD_HALF : DEG_MOD_FULL);
            end else begin
                n_f2[l] = r_f1[l];
            end
            n_f3[l]    = F3_W'(r_f2[l]) * F3_W'(RECIP_45);
            n_f4_q[l]  = r_f3[l][RECIP_SH +: QUO_W];
            n_f4_r[l]  = REM_W'(r_f3_u[l] -
                         DIFF_W'(r_f3[l][RECIP_SH +: QUO_W]) * DIFF_W'(DIV_45));
            n_f5_fp[l] = FP_W'(r_f4_r[l]) * FP_W'(RECIP_45);
            // quotient is the phase top, the remainder fraction fills the low bits
            if (l < 2) begin
                n_phase[l] = {r_f5_q[l][PHASE_W-HALF_FRAC-1:0],
                              r_f5_fp[l][RECIP_SH-1 -: HALF_FRAC]};
            end else begin
                n_phase[l] = {r_f5_q[l][PHASE_W-FULL_FRAC-1:0],
                              r_f5_fp[l][RECIP_SH-1 -: FULL_FRAC]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            for (int l = 0; l < LANES; l++) begin
                r_f1[l]    <= n_f1[l];
                r_f2[l]    <= n_f2[l];
                r_f3[l]    <= n_f3[l];
                r_f3_u[l]  <= r_f2[l];
                r_f4_q[l]  <= n_f4_q[l];
                r_f4_r[l]  <= n_f4_r[l];
                r_f5_q[l]  <= r_f4_q[l];
                r_f5_fp[l] <= n_f5_fp[l];
                r_phase[l] <= n_phase[l];
            end
        end
    end

    // sine and cosine
    logic signed [TRIG_W-1:0] s_dlat, s_dlon, c_ref, c_pt;

    hdu_sincos u_sc_dlat (
        .i_clk   (i_clk),
        .i_en    (pipe_en),
        .i_phase (r_phase[0]),
        .o_sin   (s_dlat),
        .o_cos   ()
    );

    hdu_sincos u_sc_dlon (
        .i_clk   (i_clk),
        .i_en    (pipe_en),
        .i_phase (r_phase[1]),
        .o_sin   (s_dlon),
        .o_cos   ()
    );

    hdu_sincos u_sc_ref (
        .i_clk   (i_clk),
        .i_en    (pipe_en),
        .i_phase (r_phase[2]),
        .o_sin   (),
        .o_cos   (c_ref)
    );

    hdu_sincos u_sc_pt (
        .i_clk   (i_clk),
        .i_en    (pipe_en),
        .i_phase (r_phase[3]),
        .o_sin   (),
        .o_cos   (c_pt)
    );

    // haversine term a
    logic signed [PW-1:0]   m_lat, m_lon, m_cc;
    logic signed [PW2-1:0]  m_mix;
    logic signed [AS_W-1:0] a_sum;
    logic signed [PQ_W-1:0] r_p1_lat, r_p1_lon, r_p1_cc;
    logic signed [PQ_W-1:0] r_p2_lat, r_p2_mix;
    logic [ROOT_W-1:0]      r_p3_a, n_p3_a, r_p3_b;

    always_comb begin
        m_lat = PW'(s_dlat) * PW'(s_dlat);
        m_lon = PW'(s_dlon) * PW'(s_dlon);
        m_cc  = PW'(c_ref) * PW'(c_pt);
        m_mix = PW2'(r_p1_cc) * PW2'(r_p1_lon);
        a_sum = AS_W'(r_p2_lat) + AS_W'(r_p2_mix);
        if (a_sum[AS_W-1]) begin
            n_p3_a = '0;
        end else if (a_sum > $signed(AS_W'(Q30_ONE))) begin
            n_p3_a = Q30_ONE;
        end else begin
            n_p3_a = ROOT_W'(a_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_p1_lat <= PQ_W'(m_lat >>> Q30_FRAC);
            r_p1_lon <= PQ_W'(m_lon >>> Q30_FRAC);
            r_p1_cc  <= PQ_W'(m_cc >>> Q30_FRAC);
            r_p2_lat <= r_p1_lat;
            r_p2_mix <= PQ_W'(m_mix >>> Q30_FRAC);
            r_p3_a   <= n_p3_a;
            r_p3_b   <= Q30_ONE - n_p3_a;
        end
    end

    // roots of a and 1 - a
    logic [ROOT_W-1:0] root_y, root_x;

    hdu_isqrt u_sqrt_a (
        .i_clk  (i_clk),
        .i_en   (pipe_en),
        .i_a    (r_p3_a),
        .o_root (root_y)
    );

    hdu_isqrt u_sqrt_b (
        .i_clk  (i_clk),
        .i_en   (pipe_en),
        .i_a    (r_p3_b),
        .o_root (root_x)
    );

    // cordic vectoring for atan2(y, x)
    logic signed [XY_W-1:0] r_v_x [CORDIC_ITERS], n_v_x [CORDIC_ITERS];
    logic signed [XY_W-1:0] r_v_y [CORDIC_ITERS], n_v_y [CORDIC_ITERS];
    logic signed [XY_W-1:0] r_v_z [CORDIC_ITERS], n_v_z [CORDIC_ITERS];
    logic signed [XY_W-1:0] vx_src [CORDIC_ITERS];
    logic signed [XY_W-1:0] vy_src [CORDIC_ITERS];
    logic signed [XY_W-1:0] vz_src [CORDIC_ITERS];

    always_comb begin
        vx_src[0] = XY_W'(root_x);
        vy_src[0] = XY_W'(root_y);
        vz_src[0] = '0;
        for (int i = 1; i < CORDIC_ITERS; i++) begin
            vx_src[i] = r_v_x[i-1];
            vy_src[i] = r_v_y[i-1];
            vz_src[i] = r_v_z[i-1];
        end
        for (int i = 0; i < CORDIC_ITERS; i++) begin
            if (vy_src[i][XY_W-1]) begin
                n_v_x[i] = vx_src[i] - (vy_src[i] >>> i);
                n_v_y[i] = vy_src[i] + (vx_src[i] >>> i);
                n_v_z[i] = vz_src[i] - XY_W'(atan_phase(i));
            end else if (vy_src[i] != '0) begin
                n_v_x[i] = vx_src[i] + (vy_src[i] >>> i);
                n_v_y[i] = vy_src[i] - (vx_src[i] >>> i);
                n_v_z[i] = vz_src[i] + XY_W'(atan_phase(i));
            end else begin
                // y already zero: the vector stays put
                n_v_x[i] = vx_src[i];
                n_v_y[i] = vy_src[i];
                n_v_z[i] = vz_src[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            for (int i = 0; i < CORDIC_ITERS; i++) begin
                r_v_x[i] <= n_v_x[i];
                r_v_y[i] <= n_v_y[i];
                r_v_z[i] <= n_v_z[i];
            end
        end
    end

    // scaling by radius and pi, with rounding and saturation
    logic [ROOT_W-1:0]  z_clamp;
    logic [M1_W-1:0]    r_m1;
    logic [LO_W-1:0]    r_m2_lo;
    logic [HI_W-1:0]    r_m2_hi;
    logic [SUM_W-1:0]   r_m3;
    logic [RES_W-1:0]   res;
    logic [DIST_W-1:0]  r_dist, n_dist;

    always_comb begin
        if (r_v_z[CORDIC_ITERS-1][XY_W-1]) begin
            z_clamp = '0;
        end else if (r_v_z[CORDIC_ITERS-1] > $signed(XY_W'(Q30_ONE))) begin
            z_clamp = Q30_ONE;
        end else begin
            z_clamp = ROOT_W'(r_v_z[CORDIC_ITERS-1]);
        end
        res = r_m3[SUM_W-1:ROUND_SH];
        if (res[RES_W-1]) begin
            n_dist = DIST_MAX;
        end else begin
            n_dist = res[DIST_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_m1    <= M1_W'(z_clamp) * M1_W'(r_radius);
            r_m2_lo <= LO_W'(r_m1[SPLIT-1:0]) * LO_W'(PI_Q16);
            r_m2_hi <= HI_W'(r_m1[M1_W-1:SPLIT]) * HI_W'(PI_Q16);
            r_m3    <= (SUM_W'(r_m2_hi) << SPLIT) + SUM_W'(r_m2_lo) +
                       (SUM_W'(1) << (ROUND_SH - 1));
            r_dist  <= n_dist;
        end
    end

    assign o_distance = r_dist;

endmodule

// ----- rtl/hdu_checker.sv -----
// ----------------------------------------------------------------------------
// hdu_checker
// Port-level checks of the haversine distance unit, bound to the top level.
// ----------------------------------------------------------------------------
module hdu_checker
    import hdu_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_stall,
    input logic              o_valid,
    input logic              i_stall,
    input logic [DIST_W-1:0] o_distance
);

    // input side only backs up behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held result");

    // a held result must stop new requests
    a_stall_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> o_stall)
        else $error("input taken while result held");

    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_distance <= DIST_PEAK))
        else $error("distance beyond reachable range");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_distance)))
        else $error("held result changed");

endmodule

bind haversine_distance_unit hdu_checker u_hdu_checker (.*);
